/* hw/rtl/deadline_task_scheduler_macros.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef DEADLINE_TASK_SCHEDULER_MACROS_SVH
`define DEADLINE_TASK_SCHEDULER_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define DTS_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds in the cycle after trig.
`define DTS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* hw/rtl/dts_pkg.sv */
// Shared types, codes and constants of the deadline task scheduler.
`default_nettype none
package dts_pkg;

	localparam int DEF_TASK_SLOTS = 16;
	// Slot address field wide enough for the largest table (64 slots)
	localparam int SLOT_W_MAX = 6;

	localparam logic [31:0] WINDOW_RESET = 32'd10000;
	localparam logic [9:0]  US_PER_MS    = 10'd1000;
	localparam logic [31:0] RV_DISABLE   = 32'hFFFF_FFFF;

	// Command codes
	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_ENABLE   = 2'd1;
	localparam logic [1:0] CMD_SCAN     = 2'd2;
	localparam logic [1:0] CMD_COMPLETE = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_STATUS   = 2'd0;
	localparam logic [1:0] KIND_DISPATCH = 2'd1;
	localparam logic [1:0] KIND_WAKE     = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_UNUSED = 2'd2;

	// Classified operation handed from the front to the back
	typedef enum logic [2:0] {
		OP_ADD,
		OP_ADD_FULL,
		OP_ENABLE,
		OP_SCAN,
		OP_COMPLETE,
		OP_UNUSED
	} op_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [3:0]         task_index;
		logic [63:0]        now_us;
		logic [31:0]        period_ms;
		logic               start_enabled;
		logic signed [31:0] return_value;
	} dts_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [1:0]  status;
		logic [63:0] time_us;
		logic        last;
	} dts_rsp_t;

	typedef struct packed {
		op_t                   op;
		logic [SLOT_W_MAX-1:0] slot;
		logic [SLOT_W_MAX:0]   used;
		logic [63:0]           now_us;
		logic [31:0]           arg;
		logic                  start_en;
	} dts_op_t;

endpackage
`default_nettype wire

/* hw/rtl/dts_chan_if.sv */
// Valid/ready channel carrying one payload item.
`default_nettype none
interface dts_chan_if #(
	parameter type payload_t = logic [31:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/deadline_task_scheduler.sv */
// Deadline task scheduler: slot table with add, enable, scan and complete commands.
// Items enter on req and are classified by a front end (slot bookkeeping, full and
// not-in-use checks) into a two-entry queue, so up to two further commands are taken
// while the back end works. The back end runs one command at a time: add, enable and
// error results come from S_STATUS; complete does a period read, a multiply and a
// saturating add; scan reads each slot in use in turn through the single registered
// read port of the deadline memory. Results leave through an output register that
// frees up as soon as rsp.ready is seen; backpressure on rsp stalls the back end,
// and the front end once the queue fills. The sleep window register on cfg is
// written in any cycle and must only change while the block is idle.
`default_nettype none
module deadline_task_scheduler #(
	parameter int TASK_SLOTS = dts_pkg::DEF_TASK_SLOTS
) (
	input  logic       clk,
	input  logic       arst_n,
	dts_chan_if.sink   req,
	dts_chan_if.sink   cfg,
	dts_chan_if.source rsp
);
	import dts_pkg::*;

	logic    push;
	logic    q_full;
	logic    pop;
	logic    q_empty;
	dts_op_t push_op;
	dts_op_t pop_op;

	// Accept and classify
	dts_front #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.push    (push),
		.push_op (push_op),
		.q_full  (q_full)
	);

	// Decouple front and back
	dts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	// Execute and report
	dts_back #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.op_in  (pop_op),
		.empty  (q_empty),
		.pop    (pop),
		.cfg    (cfg),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

/* hw/rtl/dts_front.sv */
// Front end: accepts commands, tracks slot use and classifies each item.
`default_nettype none
module dts_front #(
	parameter int TASK_SLOTS = dts_pkg::DEF_TASK_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	dts_chan_if.sink         req,
	output logic             push,
	output dts_pkg::dts_op_t push_op,
	input  logic             q_full
);
	import dts_pkg::*;

	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam int UW = SLOT_W_MAX + 1;

	logic [CW-1:0] used_q;
	logic [UW-1:0] used_ext;
	logic [UW-1:0] idx_ext;
	logic          tbl_full;
	logic          not_used;

	// Take an item whenever the queue has room
	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	assign used_ext = UW'(used_q);
	assign idx_ext  = UW'(req.payload.task_index);
	assign tbl_full = (used_ext == UW'(TASK_SLOTS));
	assign not_used = (idx_ext >= used_ext);

	// Classify the command against the current slot count
	always_comb begin
		push_op          = '0;
		push_op.now_us   = req.payload.now_us;
		push_op.used     = used_ext;
		push_op.start_en = req.payload.start_enabled;
		push_op.op       = OP_SCAN;
		unique case (req.payload.command)
			CMD_ADD: begin
				if (tbl_full) begin
					push_op.op = OP_ADD_FULL;
				end else begin
					push_op.op   = OP_ADD;
					push_op.slot = used_ext[SLOT_W_MAX-1:0];
					push_op.arg  = req.payload.period_ms;
				end
			end
			CMD_ENABLE: begin
				push_op.op   = not_used ? OP_UNUSED : OP_ENABLE;
				push_op.slot = idx_ext[SLOT_W_MAX-1:0];
			end
			CMD_SCAN: begin
				push_op.op = OP_SCAN;
			end
			CMD_COMPLETE: begin
				push_op.op   = not_used ? OP_UNUSED : OP_COMPLETE;
				push_op.slot = idx_ext[SLOT_W_MAX-1:0];
				push_op.arg  = 32'(req.payload.return_value);
			end
		endcase
	end

	// Claim the next slot on a successful add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (push && req.payload.command == CMD_ADD && !tbl_full) begin
			used_q <= used_q + CW'(1);
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/dts_queue.sv */
// Short queue of classified operations between front and back.
`default_nettype none
module dts_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dts_pkg::dts_op_t push_op,
	output logic             full,
	input  logic             pop,
	output dts_pkg::dts_op_t pop_op,
	output logic             empty
);
	import dts_pkg::*;

	`include "deadline_task_scheduler_macros.svh"

	localparam int QD = 2;
	localparam int PW = $clog2(QD);
	localparam int CW = $clog2(QD + 1);

	dts_op_t       ent_q [QD];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(QD));
	assign empty  = (cnt_q == '0);
	assign pop_op = ent_q[rd_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`DTS_ASSERT_NOW(QUE_NO_OVERFLOW, push, cnt_q != CW'(QD), "push into full queue")
	`DTS_ASSERT_NOW(QUE_NO_UNDERFLOW, pop, cnt_q != '0, "pop from empty queue")

endmodule
`default_nettype wire

/* hw/rtl/dts_back.sv */
// Back end: slot table, deadline arithmetic, scan sequencer and result register.
`default_nettype none
module dts_back #(
	parameter int TASK_SLOTS = dts_pkg::DEF_TASK_SLOTS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dts_pkg::dts_op_t op_in,
	input  logic             empty,
	output logic             pop,
	dts_chan_if.sink         cfg,
	dts_chan_if.source       rsp
);
	import dts_pkg::*;

	`include "deadline_task_scheduler_macros.svh"

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int UW = SLOT_W_MAX + 1;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_STATUS = 10'b00_0000_0010,
		S_CRD    = 10'b00_0000_0100,
		S_CMUL   = 10'b00_0000_1000,
		S_CFIN   = 10'b00_0001_0000,
		S_SMUL   = 10'b00_0010_0000,
		S_SINIT  = 10'b00_0100_0000,
		S_SRD    = 10'b00_1000_0000,
		S_SCHK   = 10'b01_0000_0000,
		S_SWAKE  = 10'b10_0000_0000
	} state_t;

	state_t          state_q;
	state_t          state_d;
	dts_op_t         op_q;
	logic [31:0]     win_q;
	logic [TASK_SLOTS-1:0] en_q;
	logic [63:0]     dl_mem [TASK_SLOTS];
	logic [31:0]     per_mem [TASK_SLOTS];
	logic [63:0]     dl_rd_q;
	logic [31:0]     per_rd_q;
	logic [41:0]     prod_q;
	logic [63:0]     wake_q;
	logic [SW-1:0]   i_q;
	logic            out_valid_q;
	dts_rsp_t        out_q;

	logic            can_load;
	logic            load;
	dts_rsp_t        rsp_d;
	logic [SW-1:0]   addr;
	logic            rv_pos;
	logic [31:0]     per_sel;
	logic [31:0]     mul_a;
	logic [41:0]     mul_p;
	logic [64:0]     sum65;
	logic [63:0]     sat_sum;
	logic            due;
	logic            scan_end;
	logic            dl_we;
	logic [63:0]     dl_wdata;
	logic            per_we;
	logic            en_we;
	logic            en_val;
	logic            prod_ld;
	logic            wake_init;
	logic            wake_dl;
	logic            i_clr;
	logic            i_inc;

	assign can_load = !out_valid_q || rsp.ready;
	assign addr     = op_q.slot[SW-1:0];

	// New period: a positive return value replaces the stored one
	assign rv_pos  = (op_q.arg != '0) && !op_q.arg[31];
	assign per_sel = rv_pos ? op_q.arg : per_rd_q;

	// One shared multiplier for window and period scaling to microseconds
	assign mul_a = (state_q == S_SMUL) ? win_q : per_sel;
	assign mul_p = 42'(mul_a) * 42'(US_PER_MS);

	// Saturating add of the registered product onto now
	assign sum65   = {1'b0, op_q.now_us} + 65'(prod_q);
	assign sat_sum = sum65[64] ? '1 : sum65[63:0];

	assign due      = en_q[i_q] && (op_q.now_us >= dl_rd_q);
	assign scan_end = ((UW'(i_q) + UW'(1)) == op_q.used);

	// Sequence one operation at a time
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		rsp_d     = '0;
		dl_we     = 1'b0;
		dl_wdata  = op_q.now_us;
		per_we    = 1'b0;
		en_we     = 1'b0;
		en_val    = 1'b0;
		prod_ld   = 1'b0;
		wake_init = 1'b0;
		wake_dl   = 1'b0;
		i_clr     = 1'b0;
		i_inc     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (op_in.op)
						OP_COMPLETE: state_d = S_CRD;
						OP_SCAN:     state_d = S_SMUL;
						default:     state_d = S_STATUS;
					endcase
				end
			end
			S_STATUS: begin
				if (can_load) begin
					load         = 1'b1;
					rsp_d.kind   = KIND_STATUS;
					rsp_d.slot   = op_q.slot[3:0];
					rsp_d.status = ST_OK;
					rsp_d.last   = 1'b1;
					unique case (op_q.op)
						OP_ADD: begin
							rsp_d.time_us = op_q.now_us;
							dl_we         = 1'b1;
							per_we        = 1'b1;
							en_we         = 1'b1;
							en_val        = op_q.start_en;
						end
						OP_ENABLE: begin
							rsp_d.time_us = op_q.now_us;
							dl_we         = 1'b1;
							en_we         = 1'b1;
							en_val        = 1'b1;
						end
						OP_ADD_FULL: begin
							rsp_d.slot   = '0;
							rsp_d.status = ST_FULL;
						end
						default: begin
							rsp_d.status = ST_UNUSED;
						end
					endcase
					state_d = S_IDLE;
				end
			end
			S_CRD: begin
				state_d = S_CMUL;
			end
			S_CMUL: begin
				prod_ld = 1'b1;
				state_d = S_CFIN;
			end
			S_CFIN: begin
				if (can_load) begin
					load          = 1'b1;
					rsp_d.kind    = KIND_STATUS;
					rsp_d.slot    = op_q.slot[3:0];
					rsp_d.status  = ST_OK;
					rsp_d.time_us = sat_sum;
					rsp_d.last    = 1'b1;
					dl_we         = 1'b1;
					dl_wdata      = sat_sum;
					per_we        = rv_pos;
					en_we         = (op_q.arg == RV_DISABLE);
					en_val        = 1'b0;
					state_d       = S_IDLE;
				end
			end
			S_SMUL: begin
				prod_ld = 1'b1;
				state_d = S_SINIT;
			end
			S_SINIT: begin
				wake_init = 1'b1;
				i_clr     = 1'b1;
				state_d   = (op_q.used == '0) ? S_SWAKE : S_SRD;
			end
			S_SRD: begin
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (!due || can_load) begin
					if (due) begin
						load         = 1'b1;
						rsp_d.kind   = KIND_DISPATCH;
						rsp_d.slot   = 4'(i_q);
						rsp_d.status = ST_OK;
					end else if (en_q[i_q] && dl_rd_q < wake_q) begin
						wake_dl = 1'b1;
					end
					if (scan_end) begin
						state_d = S_SWAKE;
					end else begin
						i_inc   = 1'b1;
						state_d = S_SRD;
					end
				end
			end
			S_SWAKE: begin
				if (can_load) begin
					load          = 1'b1;
					rsp_d.kind    = KIND_WAKE;
					rsp_d.status  = ST_OK;
					rsp_d.time_us = wake_q;
					rsp_d.last    = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state, enable flags, window register, result valid and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			en_q        <= '0;
			win_q       <= WINDOW_RESET;
			out_valid_q <= 1'b0;
			i_q         <= '0;
		end else begin
			state_q <= state_d;
			if (en_we) begin
				en_q[addr] <= en_val;
			end
			if (cfg.valid) begin
				win_q <= cfg.payload;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (i_clr) begin
				i_q <= '0;
			end else if (i_inc) begin
				i_q <= i_q + SW'(1);
			end
		end
	end

	// Hold the operation, product, wake time and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= op_in;
		end
		if (prod_ld) begin
			prod_q <= mul_p;
		end
		if (wake_init) begin
			wake_q <= sat_sum;
		end else if (wake_dl) begin
			wake_q <= dl_rd_q;
		end
		if (load) begin
			out_q <= rsp_d;
		end
	end

	// Deadline and period memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[addr] <= dl_wdata;
		end
		dl_rd_q <= dl_mem[i_q];
		if (per_we) begin
			per_mem[addr] <= op_q.arg;
		end
		per_rd_q <= per_mem[addr];
	end

	assign cfg.ready   = 1'b1;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	`DTS_ASSERT_NOW(BK_LOAD_FREE, load, !out_valid_q || rsp.ready, "result register overwritten")
	`DTS_ASSERT_NOW(BK_SCAN_RANGE, state_q == S_SCHK, UW'(i_q) < op_q.used, "scan past slots in use")
	`DTS_ASSERT_NEXT(BK_POP_BUSY, pop, state_q != S_IDLE, "popped operation not started")

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the deadline task scheduler: directed and random commands.
`default_nettype none
module tb_top;
	import dts_pkg::*;

	localparam int SLOT_COUNT = DEF_TASK_SLOTS;

	// Predicts scheduler results and checks them against what the block returns
	class sched_scoreboard;
		logic [31:0] window_ms;
		int unsigned used;
		bit          slot_on[SLOT_COUNT];
		logic [63:0] due_at[SLOT_COUNT];
		logic [31:0] period_ms[SLOT_COUNT];
		dts_rsp_t    pending_results[$];
		int unsigned errors;

		function new();
			window_ms = WINDOW_RESET;
			used = 0;
			errors = 0;
			foreach (slot_on[i]) begin
				slot_on[i] = 1'b0;
				due_at[i] = '0;
				period_ms[i] = '0;
			end
		endfunction

		// Add two times, clamping at the largest time value
		function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		function void queue_result(logic [1:0] kind, logic [3:0] slot, logic [1:0] status,
				logic [63:0] t, logic last);
			dts_rsp_t e;
			e.kind = kind;
			e.slot = slot;
			e.status = status;
			e.time_us = t;
			e.last = last;
			pending_results.push_back(e);
		endfunction

		// Update the slot table for one accepted item and queue its results
		function void note_request(dts_req_t r);
			logic [63:0] wake;
			int i;
			case (r.command)
				CMD_ADD: begin
					if (used >= SLOT_COUNT) begin
						queue_result(KIND_STATUS, '0, ST_FULL, '0, 1'b1);
					end else begin
						period_ms[used] = r.period_ms;
						due_at[used] = r.now_us;
						slot_on[used] = r.start_enabled;
						queue_result(KIND_STATUS, 4'(used), ST_OK, r.now_us, 1'b1);
						used++;
					end
				end
				CMD_ENABLE: begin
					if (r.task_index >= used) begin
						queue_result(KIND_STATUS, r.task_index, ST_UNUSED, '0, 1'b1);
					end else begin
						slot_on[r.task_index] = 1'b1;
						due_at[r.task_index] = r.now_us;
						queue_result(KIND_STATUS, r.task_index, ST_OK, r.now_us, 1'b1);
					end
				end
				CMD_SCAN: begin
					wake = sat_sum(r.now_us, 64'(window_ms) * 64'(US_PER_MS));
					for (i = 0; i < int'(used); i++) begin
						if (!slot_on[i])
							continue;
						if (r.now_us >= due_at[i])
							queue_result(KIND_DISPATCH, 4'(i), ST_OK, '0, 1'b0);
						else if (due_at[i] < wake)
							wake = due_at[i];
					end
					queue_result(KIND_WAKE, '0, ST_OK, wake, 1'b1);
				end
				default: begin
					if (r.task_index >= used) begin
						queue_result(KIND_STATUS, r.task_index, ST_UNUSED, '0, 1'b1);
					end else begin
						// Fold the return value: disable, new period, or keep
						if (r.return_value === RV_DISABLE)
							slot_on[r.task_index] = 1'b0;
						else if (r.return_value > 0)
							period_ms[r.task_index] = r.return_value;
						due_at[r.task_index] = sat_sum(r.now_us,
							64'(period_ms[r.task_index]) * 64'(US_PER_MS));
						queue_result(KIND_STATUS, r.task_index, ST_OK,
							due_at[r.task_index], 1'b1);
					end
				end
			endcase
		endfunction

		function void note_error();
			errors++;
		endfunction

		// Compare one returned item with the oldest expectation
		function void check_result(dts_rsp_t got);
			dts_rsp_t want;
			if (pending_results.size() == 0) begin
				note_error();
				if (errors <= 10)
					$display("unexpected result: kind=%0d slot=%0d status=%0d time=%0h last=%0d",
						got.kind, got.slot, got.status, got.time_us, got.last);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.slot !== want.slot ||
					got.status !== want.status || got.time_us !== want.time_us ||
					got.last !== want.last) begin
				note_error();
				if (errors <= 10) begin
					$display("mismatch: want kind=%0d slot=%0d status=%0d time=%0h last=%0d",
						want.kind, want.slot, want.status, want.time_us, want.last);
					$display("          got  kind=%0d slot=%0d status=%0d time=%0h last=%0d",
						got.kind, got.slot, got.status, got.time_us, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dts_chan_if #(.payload_t(dts_req_t))    req_if ();
	dts_chan_if #(.payload_t(logic [31:0])) cfg_if ();
	dts_chan_if #(.payload_t(dts_rsp_t))    rsp_if ();

	deadline_task_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.cfg    (cfg_if),
		.rsp    (rsp_if)
	);

	sched_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic [63:0] clock_us = 64'd10000;

	// Free-running clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Drive the result side ready, stalling at the current rate
	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every accepted result item
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.payload);
	end

	function automatic dts_req_t make_item(logic [1:0] cmd, logic [3:0] idx, logic [63:0] now,
			logic [31:0] period, logic en, logic [31:0] rv);
		dts_req_t r;
		r.command = cmd;
		r.task_index = idx;
		r.now_us = now;
		r.period_ms = period;
		r.start_enabled = en;
		r.return_value = rv;
		return r;
	endfunction

	// Build one random command around a slowly advancing time base
	function automatic dts_req_t random_request();
		dts_req_t r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 14)
			r.command = CMD_ADD;
		else if (pick < 30)
			r.command = CMD_ENABLE;
		else if (pick < 62)
			r.command = CMD_SCAN;
		else
			r.command = CMD_COMPLETE;
		if (sb.used > 0 && $urandom_range(99) < 85)
			r.task_index = 4'($urandom_range(sb.used - 1));
		else
			r.task_index = 4'($urandom_range(15));
		// Mostly advance the time base; now and then use an arbitrary time
		if ($urandom_range(99) < 6) begin
			r.now_us = {$urandom, $urandom};
		end else begin
			clock_us += 64'($urandom_range(2500));
			r.now_us = clock_us;
		end
		pick = $urandom_range(9);
		if (pick < 8)
			r.period_ms = $urandom_range(6, 1);
		else if (pick == 8)
			r.period_ms = '0;
		else
			r.period_ms = $urandom;
		r.start_enabled = ($urandom_range(3) != 0);
		pick = $urandom_range(9);
		if (pick < 4)
			r.return_value = $urandom_range(6, 1);
		else if (pick < 6)
			r.return_value = RV_DISABLE;
		else if (pick == 6)
			r.return_value = '0;
		else
			r.return_value = $urandom;
		return r;
	endfunction

	// Offer one command item, with an optional idle gap first
	task automatic send_request(input dts_req_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= item;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(item);
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [31:0] w);
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= w;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.window_ms = w;
	endtask

	// Stop a hung run
	initial begin
		#12000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [31:0] windows[4];
		int send_rates[4];
		int stall_rates[4];
		int p;
		windows = '{32'd3, 32'hFFFF_FFFF, 32'd1, WINDOW_RESET};
		send_rates = '{0, 56, 0, 10};
		stall_rates = '{0, 0, 56, 10};
		sb = new();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: scan, and enable/complete on slots not in use
		send_request(make_item(CMD_SCAN, 4'd0, 64'd0, '0, 1'b0, '0));
		send_request(make_item(CMD_ENABLE, 4'd0, 64'd500, '0, 1'b0, '0));
		send_request(make_item(CMD_COMPLETE, 4'd15, 64'd500, '0, 1'b0, '0));
		// A few slots: normal, disabled with zero period, largest period
		send_request(make_item(CMD_ADD, 4'd0, 64'd1000, 32'd2, 1'b1, '0));
		send_request(make_item(CMD_ADD, 4'd9, 64'd1000, 32'd0, 1'b0, '0));
		send_request(make_item(CMD_ADD, 4'd0, 64'd1500, 32'hFFFF_FFFF, 1'b1, '0));
		send_request(make_item(CMD_SCAN, 4'd0, 64'd1000, '0, 1'b0, '0));
		// Return values: new period, zero, disable, negative, largest
		send_request(make_item(CMD_COMPLETE, 4'd0, 64'd1200, '0, 1'b0, 32'd3));
		send_request(make_item(CMD_COMPLETE, 4'd1, 64'd1300, '0, 1'b0, 32'd0));
		send_request(make_item(CMD_COMPLETE, 4'd2, 64'd2000, '0, 1'b0, RV_DISABLE));
		send_request(make_item(CMD_COMPLETE, 4'd0, 64'd2500, '0, 1'b0, 32'h8000_0000));
		send_request(make_item(CMD_COMPLETE, 4'd0, 64'hFFFF_FFFF_FFFF_0000, '0, 1'b0,
			32'h7FFF_FFFF));
		send_request(make_item(CMD_ENABLE, 4'd1, 64'd3000, '0, 1'b0, '0));
		send_request(make_item(CMD_ENABLE, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0));
		send_request(make_item(CMD_SCAN, 4'd0, 64'd3000, '0, 1'b0, '0));
		// Wake time saturates near the top of the time range
		send_request(make_item(CMD_SCAN, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1'b0, '0));
		send_request(make_item(CMD_ENABLE, 4'd15, 64'd4000, '0, 1'b0, '0));
		send_request(make_item(CMD_COMPLETE, 4'd3, 64'd4000, '0, 1'b0, 32'd5));
		// Zero window caps the wake time at now
		wait_idle();
		write_window('0);
		send_request(make_item(CMD_SCAN, 4'd0, 64'd5000, '0, 1'b0, '0));
		send_request(make_item(CMD_SCAN, 4'd0, 64'd0, '0, 1'b0, '0));

		// Random phases, each with its own window and idle pattern
		for (p = 0; p < 4; p++) begin
			wait_idle();
			write_window(windows[p]);
			send_idle_pct = send_rates[p];
			recv_stall_pct = stall_rates[p];
			repeat (50) send_request(random_request());
		end

		wait_idle();
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
